[hw/rtl/d2eo_pkg.sv]
// Package for the 2x2 ordered dither with edge overlay.
// Holds item and tap types, register codes and the gray, level and pattern functions.
// No dependencies.
package d2eo_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd3;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [10:0] RST_HEIGHT = 11'd200;
    localparam logic [2:0]  RST_PLANE  = 3'd7;
    localparam logic [7:0]  RST_THRESH = 8'd64;

    localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef struct packed {
        logic        func;
        logic [23:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        frame_end;
    } t_out_item;

    // one pixel as held in line buffers and the window
    typedef struct packed {
        logic [7:0]  gray;
        logic [23:0] rgb;
    } t_tap;

    // what the position of an item says about the result it releases
    typedef struct packed {
        logic has_result;
        logic interior;
        logic leftover;
        logic x_odd;
        logic y_odd;
        logic frame_end;
        logic in_frame;
    } t_pos_info;

    // floor((30*b0 + 59*b2 + 11*b1) / 100), divide by reciprocal 5243 / 2^19
    function automatic logic [7:0] gray_of(input logic [23:0] px);
        logic [14:0] num;
        logic [27:0] prod;
        num  = 15'(px[7:0]) * 15'd30 + 15'(px[23:16]) * 15'd59 + 15'(px[15:8]) * 15'd11;
        prod = 28'(num) * 28'd5243;
        return prod[26:19];
    endfunction

    // floor(sum / 205), sum of four bytes
    function automatic logic [2:0] level_of(input logic [9:0] sum);
        logic [2:0] lvl;
        if (sum >= 10'd820)      lvl = 3'd4;
        else if (sum >= 10'd615) lvl = 3'd3;
        else if (sum >= 10'd410) lvl = 3'd2;
        else if (sum >= 10'd205) lvl = 3'd1;
        else                     lvl = 3'd0;
        return lvl;
    endfunction

    // 2x2 pattern table, sel = {y[0], x[0]}
    function automatic logic pattern_on(input logic [2:0] lvl, input logic [1:0] sel);
        logic on;
        case (lvl)
            3'd1:    on = (sel == 2'd0);
            3'd2:    on = (sel == 2'd0) || (sel == 2'd3);
            3'd3:    on = (sel != 2'd2);
            3'd4:    on = 1'b1;
            default: on = 1'b0;
        endcase
        return on;
    endfunction

endpackage

[hw/rtl/dither_2x2_edge_overlay_top.sv]
// Top level of the 2x2 ordered dither with edge overlay.
// Instantiates d2eo_ctrl, d2eo_linebuf and d2eo_window; uses d2eo_pkg.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------
//  in      | sink      | i_in_valid, i_in_data, o_in_stall
//  out     | source    | o_out_valid, o_out_data, i_out_stall
//  cfg     | sink      | i_cfg_we, i_cfg_idx, i_cfg_data
//
// One item per clock while the output is not stalled; the result that an item releases
// passes the input stage register and then the output register.
// Line memories are read at the column of the incoming item and written
// when it leaves the input stage; the window then takes its column.
// Synchronous active-low reset loads config reset values, clears position and valid flags.
// Output stall with a result held freezes the whole pipe; input stall is asserted only then.
module dither_2x2_edge_overlay_top import d2eo_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);

    logic          en;
    logic          accept;
    logic [XW-1:0] col;
    t_pos_info     info;
    logic [2:0]    plane;
    logic [7:0]    thresh;
    t_tap          row1;
    t_tap          row2;
    t_tap          new_tap;
    t_out_item     result;

    logic          r_s1_valid;
    t_pos_info     r_s1_info;
    logic [23:0]   r_s1_pixel;
    logic [XW-1:0] r_s1_addr;
    logic          r_out_valid;
    t_out_item     r_out_data;

    assign en     = !r_out_valid || !i_out_stall;
    assign accept = i_in_valid && en;
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign new_tap.gray = gray_of(r_s1_pixel);
    assign new_tap.rgb  = r_s1_pixel;

    d2eo_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (accept),
        .o_col      (col),
        .o_info     (info),
        .o_plane    (plane),
        .o_thresh   (thresh)
    );

    d2eo_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .XW        (XW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (en),
        .i_rd_addr (col),
        .i_wr_en   (en && r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (new_tap),
        .o_row1    (row1),
        .o_row2    (row2)
    );

    d2eo_window u_window (
        .i_clk    (i_clk),
        .i_adv    (en && r_s1_valid),
        .i_top    (row2),
        .i_mid    (row1),
        .i_bot    (new_tap),
        .i_info   (r_s1_info),
        .i_plane  (plane),
        .i_thresh (thresh),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= accept;
            r_out_valid <= r_s1_valid && r_s1_info.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info  <= info;
            r_s1_pixel <= (info.in_frame && !i_in_data.func) ? i_in_data.pixel_in : 24'd0;
            r_s1_addr  <= col;
        end
        if (en) begin
            r_out_data <= result;
        end
    end

endmodule

[hw/rtl/d2eo_ctrl.sv]
// Configuration registers and stream position counters.
// Decodes the position of the next item into result flags. Uses d2eo_pkg.
module d2eo_ctrl import d2eo_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int XW         = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_advance,
    output logic [XW-1:0]         o_col,
    output t_pos_info             o_info,
    output logic [2:0]            o_plane,
    output logic [7:0]            o_thresh
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 2);

    logic [10:0]   r_cfg_width;
    logic [10:0]   r_cfg_height;
    logic [2:0]    r_plane;
    logic [7:0]    r_thresh;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [XW-1:0] n_x;
    logic [YW-1:0] n_y;

    logic [WW-1:0] w;
    logic [YW-1:0] h;
    logic [YW-1:0] h1;
    logic [XW-1:0] cur_x;
    logic [YW-1:0] cur_y;
    logic [WW-1:0] x_ext;
    logic [WW-1:0] x_p;
    logic [YW-1:0] y_p;
    logic          bad;
    logic          xz;
    logic          is_last;

    always_comb begin
        if (r_cfg_width < 11'd3) begin
            w = WW'(3);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_cfg_width);
        end
        if (r_cfg_height < 11'd3) begin
            h = YW'(3);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h = YW'(MAX_HEIGHT);
        end else begin
            h = YW'(r_cfg_height);
        end
        h1 = h + YW'(1);

        bad   = (WW'(r_x) >= w) || (r_y > h1) || ((r_y == h1) && (r_x != '0));
        cur_x = bad ? '0 : r_x;
        cur_y = bad ? '0 : r_y;
        x_ext = WW'(cur_x);
        xz    = (cur_x == '0);
        is_last = (cur_y == h1) && xz;

        x_p = xz ? (w - WW'(1)) : (x_ext - WW'(1));
        y_p = xz ? (cur_y - YW'(2)) : (cur_y - YW'(1));

        o_info.has_result = (cur_y >= YW'(2)) || ((cur_y == YW'(1)) && !xz);
        o_info.interior   = !xz && (y_p >= YW'(1)) && ((y_p + YW'(1)) < h)
                            && (x_p >= WW'(1)) && ((x_p + WW'(1)) < w);
        o_info.leftover   = (!y_p[0] && (y_p == h - YW'(1)))
                            || (!x_p[0] && (x_p == w - WW'(1)));
        o_info.x_odd      = x_p[0];
        o_info.y_odd      = y_p[0];
        o_info.frame_end  = is_last;
        o_info.in_frame   = (cur_y < h);

        if (is_last) begin
            n_x = '0;
            n_y = '0;
        end else if (x_ext == w - WW'(1)) begin
            n_x = '0;
            n_y = cur_y + YW'(1);
        end else begin
            n_x = cur_x + XW'(1);
            n_y = cur_y;
        end
    end

    assign o_col    = cur_x;
    assign o_plane  = r_plane;
    assign o_thresh = r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_plane      <= RST_PLANE;
            r_thresh     <= RST_THRESH;
            r_x          <= '0;
            r_y          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_cfg_width  <= i_cfg_data;
                    REG_HEIGHT: r_cfg_height <= i_cfg_data;
                    REG_PLANE:  r_plane      <= i_cfg_data[2:0];
                    REG_THRESH: r_thresh     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_advance) begin
                r_x <= n_x;
                r_y <= n_y;
            end
        end
    end

endmodule

[hw/rtl/d2eo_linebuf.sv]
// Two chained line memories holding the previous two rows, indexed by column.
// Read data is registered; uses d2eo_pkg.
module d2eo_linebuf import d2eo_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int XW        = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [XW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [XW-1:0] i_wr_addr,
    input  t_tap          i_wr_data,
    output t_tap          o_row1,
    output t_tap          o_row2
);
    t_tap mem_row1 [MAX_WIDTH];
    t_tap mem_row2 [MAX_WIDTH];
    t_tap r_rd1;
    t_tap r_rd2;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_row1[i_wr_addr] <= i_wr_data;
            mem_row2[i_wr_addr] <= r_rd1;
        end
        if (i_rd_en) begin
            r_rd1 <= mem_row1[i_rd_addr];
            r_rd2 <= mem_row2[i_rd_addr];
        end
    end

    assign o_row1 = r_rd1;
    assign o_row2 = r_rd2;

endmodule

[hw/rtl/d2eo_window.sv]
// 3x3 neighborhood window and result logic: dilation, edge test, block dither.
// Uses d2eo_pkg.
module d2eo_window import d2eo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_adv,
    input  t_tap       i_top,
    input  t_tap       i_mid,
    input  t_tap       i_bot,
    input  t_pos_info  i_info,
    input  logic [2:0] i_plane,
    input  logic [7:0] i_thresh,
    output t_out_item  o_result
);
    t_tap r_col1 [3];
    t_tap r_col2 [3];
    t_tap nc [3];
    t_tap lc [3];
    t_tap rc [3];
    t_tap q0, q1, q2, q3;
    logic [7:0]  g;
    logic [7:0]  d;
    logic        edge_hit;
    logic [9:0]  sum;
    logic [2:0]  lvl;
    logic [23:0] lanes;
    logic [1:0]  sel;

    always_comb begin
        nc[0] = i_top;
        nc[1] = i_mid;
        nc[2] = i_bot;
        for (int i = 0; i < 3; i++) begin
            lc[i] = i_info.x_odd ? r_col1[i] : r_col2[i];
            rc[i] = i_info.x_odd ? r_col2[i] : nc[i];
        end

        g = r_col2[1].gray;
        d = g;
        if (r_col2[0].gray > d) d = r_col2[0].gray;
        if (r_col2[2].gray > d) d = r_col2[2].gray;
        if (r_col1[1].gray > d) d = r_col1[1].gray;
        if (nc[1].gray > d)     d = nc[1].gray;
        edge_hit = i_info.interior && ((d - g) > i_thresh);

        q0 = i_info.y_odd ? lc[0] : lc[1];
        q1 = i_info.y_odd ? rc[0] : rc[1];
        q2 = i_info.y_odd ? lc[1] : lc[2];
        q3 = i_info.y_odd ? rc[1] : rc[2];
        sel = {i_info.y_odd, i_info.x_odd};

        for (int j = 0; j < 3; j++) begin
            sum = 10'(q0.rgb[8*j +: 8]) + 10'(q1.rgb[8*j +: 8])
                + 10'(q2.rgb[8*j +: 8]) + 10'(q3.rgb[8*j +: 8]);
            lvl = level_of(sum);
            lanes[8*j +: 8] = (i_plane[j] && pattern_on(lvl, sel)) ? 8'hFF : 8'h00;
        end

        if (edge_hit) begin
            o_result.pixel_out = OPAQUE_BLACK;
        end else if (i_info.leftover) begin
            o_result.pixel_out = '0;
        end else begin
            o_result.pixel_out = {8'hFF, lanes};
        end
        o_result.frame_end = i_info.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_col1[i] <= r_col2[i];
                r_col2[i] <= nc[i];
            end
        end
    end

endmodule

[dv/tb_dither_2x2_edge_overlay_top.sv]
// Self-checking testbench for dither_2x2_edge_overlay_top: directed and random frames
// via the pixel stream, results checked in order against a local dither/edge predictor.
// Depends on d2eo_pkg and the RTL top level only.
module tb_dither_2x2_edge_overlay_top;
    import d2eo_pkg::*;

    localparam int WIN_DEPTH = 2 * DEF_MAX_WIDTH + 4;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_ITEMS = 1560;

    class dither_scoreboard;
        logic [10:0] width_reg, height_reg;
        logic [2:0]  plane_reg;
        logic [7:0]  thresh_reg;
        int unsigned stream_pos;
        logic [23:0] window_px[WIN_DEPTH];
        t_out_item   pending[$];
        int          errors;
        int          checked;

        function void reset_state();
            width_reg  = 11'd640;
            height_reg = 11'd200;
            plane_reg  = 3'd7;
            thresh_reg = 8'd64;
            stream_pos = 0;
            errors     = 0;
            checked    = 0;
            foreach (window_px[i]) window_px[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_WIDTH:  width_reg  = val;
                REG_HEIGHT: height_reg = val;
                REG_PLANE:  plane_reg  = val[2:0];
                REG_THRESH: thresh_reg = val[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        function logic [23:0] px_at(int unsigned q);
            return window_px[q % WIN_DEPTH];
        endfunction

        function int unsigned luma_at(int unsigned q);
            logic [23:0] px;
            px = px_at(q);
            return (30 * px[7:0] + 59 * px[23:16] + 11 * px[15:8]) / 100;
        endfunction

        function logic [31:0] shade_pixel(int unsigned p, int unsigned w, int unsigned h);
            int unsigned y, x, g, d, base, sum, lvl;
            int unsigned nb[4];
            logic [23:0] qp[4];
            logic [1:0]  sel;
            logic [31:0] res;
            logic        on;
            y = p / w;
            x = p % w;
            g = luma_at(p);
            d = g;
            if (y >= 1 && y + 1 < h && x >= 1 && x + 1 < w) begin
                nb[0] = luma_at(p - w);
                nb[1] = luma_at(p + w);
                nb[2] = luma_at(p - 1);
                nb[3] = luma_at(p + 1);
                foreach (nb[i]) if (nb[i] > d) d = nb[i];
            end
            if (d - g > thresh_reg) return OPAQUE_BLACK;
            if ((y | 1) >= h || (x | 1) >= w) return 32'h0;
            base = (y & ~32'd1) * w + (x & ~32'd1);
            sel  = {y[0], x[0]};
            res  = OPAQUE_BLACK;
            qp[0] = px_at(base);
            qp[1] = px_at(base + 1);
            qp[2] = px_at(base + w);
            qp[3] = px_at(base + w + 1);
            for (int j = 0; j < 3; j++) begin
                sum = qp[0][8*j +: 8] + qp[1][8*j +: 8]
                    + qp[2][8*j +: 8] + qp[3][8*j +: 8];
                lvl = sum / 205;
                if (lvl > 4) lvl = 4;
                case (lvl)
                    1: on = (sel == 2'd0);
                    2: on = (sel == 2'd0) || (sel == 2'd3);
                    3: on = (sel != 2'd2);
                    4: on = 1'b1;
                    default: on = 1'b0;
                endcase
                if (plane_reg[j] && on) res[8*j +: 8] = 8'hFF;
            end
            return res;
        endfunction

        function void note_input(t_in_item it);
            int unsigned w, h, total, last_pos, k, p;
            t_out_item   exp_item;
            w = clamp_dim(width_reg, DEF_MAX_WIDTH);
            h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
            total = w * h;
            last_pos = total + w;
            if (stream_pos > last_pos) stream_pos = 0;
            k = stream_pos;
            if (k < total) window_px[k % WIN_DEPTH] = it.func ? 24'h0 : it.pixel_in;
            if (k >= w + 1) begin
                p = k - (w + 1);
                exp_item.pixel_out = shade_pixel(p, w, h);
                exp_item.frame_end = (p == total - 1);
                pending = {pending, exp_item};
            end
            stream_pos = (k >= last_pos) ? 0 : k + 1;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.pixel_out !== want.pixel_out)
                report($sformatf("pixel_out %h, want %h", got.pixel_out, want.pixel_out));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dither_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;
    int frames_run = 0;
    int items_sent = 0;

    dither_2x2_edge_overlay_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_data);
    end

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [2:0] pl, logic [7:0] th);
        set_reg(REG_WIDTH, w);
        set_reg(REG_HEIGHT, h);
        set_reg(REG_PLANE, 11'(pl));
        set_reg(REG_THRESH, 11'(th));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_pixel(int style);
        logic [23:0] px;
        case (style)
            0: px = 24'($urandom);
            1: px = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            default: begin
                for (int j = 0; j < 3; j++) px[8*j +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        endcase
        return px;
    endfunction

    // one complete frame: w*h pixels then w+1 drain transfers, with some mixed-in oddities
    task automatic run_frame(int unsigned w, int unsigned h, int style);
        t_in_item it;
        for (int unsigned k = 0; k < w * h + w + 1; k++) begin
            if (k < w * h) begin
                it.func     = ($urandom_range(99) < 5);
                it.pixel_in = rand_pixel(style);
            end else begin
                it.func     = ($urandom_range(99) >= 10);
                it.pixel_in = 24'($urandom);
            end
            send_item(it);
        end
        wait_drained();
        frames_run++;
    endtask

    function automatic logic [7:0] pick_thresh();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 8'd0;
        if (r < 30) return 8'd255;
        return 8'($urandom_range(0, 80));
    endfunction

    task automatic random_phase(int s_pct, int r_pct);
        int          start;
        int unsigned w, h;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = items_sent;
        while (items_sent - start < RAND_ITEMS / 3) begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 9);
            if ($urandom_range(9) == 0) begin
                set_frame(11'($urandom_range(0, 2)), 11'($urandom_range(0, 2)),
                          3'($urandom), pick_thresh());
                w = 3;
                h = 3;
            end else begin
                set_frame(11'(w), 11'(h), 3'($urandom), pick_thresh());
            end
            run_frame(w, h, $urandom_range(2));
        end
    endtask

    initial begin
        t_in_item it;
        sb = new();
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed 4x4: extreme pixels, a drain inside the frame, data during drain
        set_frame(11'd4, 11'd4, 3'd7, 8'd0);
        for (int k = 0; k < 21; k++) begin
            case (k)
                0, 5, 10, 15: it = '{func: 1'b0, pixel_in: 24'hFFFFFF};
                3:            it = '{func: 1'b1, pixel_in: 24'hFFFFFF};
                6:            it = '{func: 1'b0, pixel_in: 24'h0000FF};
                9:            it = '{func: 1'b0, pixel_in: 24'h00FF00};
                12:           it = '{func: 1'b0, pixel_in: 24'hFF0000};
                17:           it = '{func: 1'b0, pixel_in: 24'h123456};
                default:      it = '{func: k >= 16, pixel_in: 24'h000000};
            endcase
            send_item(it);
        end
        wait_drained();

        random_phase(7, 83);
        random_phase(83, 7);
        random_phase(0, 0);

        $display("covered %0d frames, %0d input transfers, %0d results checked",
                 frames_run, items_sent, sb.checked);
        if (sb.pending.size() != 0) sb.report("results still outstanding at end");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[sim.f]
hw/rtl/d2eo_pkg.sv
hw/rtl/d2eo_ctrl.sv
hw/rtl/d2eo_linebuf.sv
hw/rtl/d2eo_window.sv
hw/rtl/dither_2x2_edge_overlay_top.sv
dv/tb_dither_2x2_edge_overlay_top.sv
